// ===== hw/rtl/hav_pkg.sv =====
// ---------------------------------------------------------------------------
// hav_pkg
// shared constants, status codes, result structs and character classes for
// the host address validator
// ---------------------------------------------------------------------------
package hav_pkg;

    localparam int HOST_LEN_LIMIT = 255;

    localparam logic [7:0] CH_HYPHEN   = 8'h2d;
    localparam logic [7:0] CH_PERIOD   = 8'h2e;
    localparam logic [7:0] CH_IPV6_SEP = 8'h3a;

    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 8;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_IPV6    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY_LABEL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EDGE_HYPHEN = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL_CH  = 3'd5;

    localparam logic [INDEX_W-1:0] LABEL_COUNT_MAX = 8'd255;
    localparam logic [3:0]         V6_GROUP_SAT    = 4'd9;
    localparam logic [2:0]         V6_DIGITS_MAX   = 3'd4;
    localparam logic [3:0]         V6_GROUPS_FULL  = 4'd8;
    localparam logic [3:0]         V6_GROUPS_SHORT = 4'd7;

    typedef struct packed {
        logic                seen_period;
        logic                too_long;
        logic [STATUS_W-1:0] label_err;
        logic [INDEX_W-1:0]  label_idx;
    } lbl_result_t;

    typedef struct packed {
        logic seen_colon;
        logic addr_ok;
    } v6_result_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic is_label_char(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], CH_HYPHEN});
    endfunction

endpackage

// ===== hw/rtl/hav_label_chk.sv =====
// ---------------------------------------------------------------------------
// hav_label_chk
// per-label hostname checks, first failing label and total length tracking
// ---------------------------------------------------------------------------
module hav_label_chk #(
    parameter int MAX_LENGTH = hav_pkg::HOST_LEN_LIMIT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           ch,
    input  logic                 has_char,
    input  logic                 last,
    output hav_pkg::lbl_result_t result
);

    localparam int LEN_W = $clog2(MAX_LENGTH + 2);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LENGTH);

    logic [LEN_W-1:0]                   total_len_reg, total_len_next;
    logic [hav_pkg::INDEX_W-1:0]        label_cnt_reg, label_cnt_next;
    logic                               nonempty_reg, nonempty_next;
    logic                               starts_hyp_reg, starts_hyp_next;
    logic                               prev_hyp_reg, prev_hyp_next;
    logic                               bad_ch_reg, bad_ch_next;
    logic                               seen_period_reg, seen_period_next;
    logic [hav_pkg::STATUS_W-1:0]       first_err_reg, first_err_next;
    logic [hav_pkg::INDEX_W-1:0]        first_lbl_reg, first_lbl_next;

    logic [hav_pkg::STATUS_W-1:0]       close_err, end_err;
    logic                               is_period, is_hyp;

    // error code of a label at the point it is closed
    function automatic logic [hav_pkg::STATUS_W-1:0] label_code(
        input logic nonempty, input logic sh, input logic ph, input logic bad);
        if (!nonempty)     return hav_pkg::ST_EMPTY_LABEL;
        else if (sh || ph) return hav_pkg::ST_EDGE_HYPHEN;
        else if (bad)      return hav_pkg::ST_ILLEGAL_CH;
        else               return hav_pkg::ST_OK;
    endfunction

    assign is_period = (ch == hav_pkg::CH_PERIOD);
    assign is_hyp    = (ch == hav_pkg::CH_HYPHEN);
    assign close_err = label_code(nonempty_reg, starts_hyp_reg, prev_hyp_reg, bad_ch_reg);

    always_comb begin
        total_len_next   = total_len_reg;
        label_cnt_next   = label_cnt_reg;
        nonempty_next    = nonempty_reg;
        starts_hyp_next  = starts_hyp_reg;
        prev_hyp_next    = prev_hyp_reg;
        bad_ch_next      = bad_ch_reg;
        seen_period_next = seen_period_reg;
        first_err_next   = first_err_reg;
        first_lbl_next   = first_lbl_reg;

        if (has_char) begin
            if (total_len_reg <= LEN_LIMIT) begin
                total_len_next = total_len_reg + 1'b1;
            end
            if (is_period) begin
                seen_period_next = 1'b1;
                if (first_err_reg == hav_pkg::ST_OK && close_err != hav_pkg::ST_OK) begin
                    first_err_next = close_err;
                    first_lbl_next = label_cnt_reg;
                end
                if (label_cnt_reg != hav_pkg::LABEL_COUNT_MAX) begin
                    label_cnt_next = label_cnt_reg + 1'b1;
                end
                nonempty_next   = 1'b0;
                starts_hyp_next = 1'b0;
                prev_hyp_next   = 1'b0;
                bad_ch_next     = 1'b0;
            end else begin
                if (!nonempty_reg) begin
                    starts_hyp_next = is_hyp;
                end
                nonempty_next = 1'b1;
                prev_hyp_next = is_hyp;
                bad_ch_next   = bad_ch_reg | ~hav_pkg::is_label_char(ch);
            end
        end

        // closing the final label
        end_err = label_code(nonempty_next, starts_hyp_next, prev_hyp_next, bad_ch_next);

        result.seen_period = seen_period_next;
        result.too_long    = (total_len_next > LEN_LIMIT);
        if (first_err_next != hav_pkg::ST_OK) begin
            result.label_err = first_err_next;
            result.label_idx = first_lbl_next;
        end else begin
            result.label_err = end_err;
            result.label_idx = label_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            total_len_reg   <= '0;
            label_cnt_reg   <= '0;
            nonempty_reg    <= 1'b0;
            starts_hyp_reg  <= 1'b0;
            prev_hyp_reg    <= 1'b0;
            bad_ch_reg      <= 1'b0;
            seen_period_reg <= 1'b0;
            first_err_reg   <= hav_pkg::ST_OK;
            first_lbl_reg   <= '0;
        end else if (step) begin
            total_len_reg   <= total_len_next;
            label_cnt_reg   <= label_cnt_next;
            nonempty_reg    <= nonempty_next;
            starts_hyp_reg  <= starts_hyp_next;
            prev_hyp_reg    <= prev_hyp_next;
            bad_ch_reg      <= bad_ch_next;
            seen_period_reg <= seen_period_next;
            first_err_reg   <= first_err_next;
            first_lbl_reg   <= first_lbl_next;
        end
    end

endmodule

// ===== hw/rtl/hav_v6_chk.sv =====
// ---------------------------------------------------------------------------
// hav_v6_chk
// pure-hex ipv6 literal grammar tracker
// ---------------------------------------------------------------------------
module hav_v6_chk (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          ch,
    input  logic                has_char,
    input  logic                last,
    output hav_pkg::v6_result_t result
);

    logic [2:0] digits_reg, digits_next;
    logic [3:0] groups_reg, groups_next;
    logic       dbl_reg, dbl_next;
    logic       prev_col_reg, prev_col_next;
    logic       invalid_reg, invalid_next;
    logic       started_reg, started_next;
    logic       seen_colon_reg, seen_colon_next;

    logic       is_col;
    logic [3:0] groups_end;

    assign is_col = (ch == hav_pkg::CH_IPV6_SEP);

    always_comb begin
        digits_next     = digits_reg;
        groups_next     = groups_reg;
        dbl_next        = dbl_reg;
        prev_col_next   = prev_col_reg;
        invalid_next    = invalid_reg;
        started_next    = started_reg;
        seen_colon_next = seen_colon_reg;

        if (has_char) begin
            started_next = 1'b1;
            if (is_col) begin
                seen_colon_next = 1'b1;
            end
            if (!invalid_reg) begin
                if (hav_pkg::is_hex(ch)) begin
                    // a single leading colon
                    if (prev_col_reg && groups_reg == '0 && !dbl_reg) begin
                        invalid_next = 1'b1;
                    end else if (digits_reg >= hav_pkg::V6_DIGITS_MAX) begin
                        invalid_next = 1'b1;
                    end else begin
                        digits_next = digits_reg + 1'b1;
                    end
                    prev_col_next = 1'b0;
                end else if (is_col) begin
                    if (digits_reg != '0) begin
                        if (groups_reg < hav_pkg::V6_GROUP_SAT) begin
                            groups_next = groups_reg + 1'b1;
                        end
                        digits_next   = '0;
                        prev_col_next = 1'b1;
                    end else if (prev_col_reg) begin
                        if (dbl_reg) begin
                            invalid_next = 1'b1;
                        end
                        dbl_next      = 1'b1;
                        prev_col_next = 1'b0;
                    end else if (!started_reg) begin
                        prev_col_next = 1'b1;
                    end else begin
                        // colon straight after a double colon
                        invalid_next = 1'b1;
                    end
                end else begin
                    invalid_next = 1'b1;
                end
            end
        end

        groups_end = groups_next + {3'b000, (digits_next != '0)};

        result.seen_colon = seen_colon_next;
        if (invalid_next || prev_col_next) begin
            result.addr_ok = 1'b0;
        end else if (dbl_next) begin
            result.addr_ok = (groups_end <= hav_pkg::V6_GROUPS_SHORT);
        end else begin
            result.addr_ok = (groups_end == hav_pkg::V6_GROUPS_FULL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            digits_reg     <= '0;
            groups_reg     <= '0;
            dbl_reg        <= 1'b0;
            prev_col_reg   <= 1'b0;
            invalid_reg    <= 1'b0;
            started_reg    <= 1'b0;
            seen_colon_reg <= 1'b0;
        end else if (step) begin
            digits_reg     <= digits_next;
            groups_reg     <= groups_next;
            dbl_reg        <= dbl_next;
            prev_col_reg   <= prev_col_next;
            invalid_reg    <= invalid_next;
            started_reg    <= started_next;
            seen_colon_reg <= seen_colon_next;
        end
    end

endmodule

// ===== hw/rtl/host_address_validator_top.sv =====
// ---------------------------------------------------------------------------
// host_address_validator_top
// streaming hostname / ipv6 literal checker, one address byte per request
// ---------------------------------------------------------------------------
// usage:
//  - input channel (s_valid/s_ready): one request per address byte, s_ch with
//    s_has_char high; s_last marks the final request of a string. a request
//    with s_has_char low carries no byte (used to end an empty tail)
//  - result channel (m_valid/m_ready): exactly one result per string, given
//    for the request with s_last high; m_status 0 ok, 1 bad ipv6, 2 too long,
//    3 empty label, 4 label edge hyphen, 5 illegal character; m_label_index
//    names the failing label for codes 3 to 5 and is 0 otherwise
//  - path: a request sits in the input register while the checkers update,
//    and the result register loads as the last request leaves it
//  - throughput: one request per cycle while no stall holds the input
//    register; the label and ipv6 trackers update between the registers
//  - stall: while an undelivered result is held, requests without s_last
//    still drain; a further last request waits in the input register and
//    s_ready drops once that register cannot move on
//  - reset: synchronous, active low; clears the valid flags of both registers
//    and all tracker state, so the next byte starts a fresh string
// ---------------------------------------------------------------------------
module host_address_validator_top #(
    parameter int MAX_LENGTH = hav_pkg::HOST_LEN_LIMIT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_ch,
    input  logic                          s_has_char,
    input  logic                          s_last,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hav_pkg::STATUS_W-1:0]  m_status,
    output logic [hav_pkg::INDEX_W-1:0]   m_label_index
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_ch_reg;
    logic       in_has_reg;
    logic       in_last_reg;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic [hav_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [hav_pkg::INDEX_W-1:0]  out_index_reg, out_index_next;

    logic                 out_free;
    logic                 consume;
    logic                 s_take;
    hav_pkg::lbl_result_t lbl_res;
    hav_pkg::v6_result_t  v6_res;

    // the held request moves on unless it needs the result register and that
    // register still holds an undelivered result
    assign out_free = !out_valid_reg || m_ready;
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || consume;
    assign s_take   = s_valid && s_ready;

    hav_label_chk #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_label (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (consume),
        .ch       (in_ch_reg),
        .has_char (in_has_reg),
        .last     (in_last_reg),
        .result   (lbl_res)
    );

    hav_v6_chk u_v6 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (consume),
        .ch       (in_ch_reg),
        .has_char (in_has_reg),
        .last     (in_last_reg),
        .result   (v6_res)
    );

    // colon rules take precedence, then the length limit, then label errors
    always_comb begin
        out_index_next = '0;
        if (v6_res.seen_colon) begin
            if (lbl_res.seen_period || !v6_res.addr_ok) begin
                out_status_next = hav_pkg::ST_BAD_IPV6;
            end else begin
                out_status_next = hav_pkg::ST_OK;
            end
        end else if (lbl_res.too_long) begin
            out_status_next = hav_pkg::ST_TOO_LONG;
        end else begin
            out_status_next = lbl_res.label_err;
            if (lbl_res.label_err != hav_pkg::ST_OK) begin
                out_index_next = lbl_res.label_idx;
            end
        end
    end

    assign in_valid_next = s_take ? 1'b1 : (consume ? 1'b0 : in_valid_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (consume && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_ch_reg   <= s_ch;
            in_has_reg  <= s_has_char;
            in_last_reg <= s_last;
        end
        if (consume && in_last_reg) begin
            out_status_reg <= out_status_next;
            out_index_reg  <= out_index_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_label_index = out_index_reg;

endmodule
